@@ hw/rtl/resampling_audio_ring_buffer_top_assert.svh @@
// Assertion macros for the resampling audio ring buffer.
`ifndef RESAMPLING_AUDIO_RING_BUFFER_TOP_ASSERT_SVH
`define RESAMPLING_AUDIO_RING_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define RARB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rarb assertion failed");

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define RARB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rarb assertion failed");

`endif

@@ hw/rtl/rarb_pkg.sv @@
// Shared types and constants of the resampling audio ring buffer.
`default_nettype none

package rarb_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PHASE_W  = 12;
  localparam int unsigned STEP_W   = 13;
  localparam int unsigned WCOUNT_W = 7;
  localparam int unsigned BCOUNT_W = 11;
  localparam int unsigned DIFF_W   = SAMPLE_W + 1;
  localparam int unsigned PROD_W   = DIFF_W + PHASE_W + 1;
  localparam int unsigned ENTRY_W  = 2 * SAMPLE_W;

  localparam logic [STEP_W-1:0] STEP_MIN   = 13'd64;
  localparam logic [STEP_W-1:0] STEP_MAX   = 13'd4096;
  localparam logic [STEP_W-1:0] STEP_RESET = 13'd4096;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_first;
    logic start_gen;
    logic gen_step;
    logic finish_gen;
    logic drain_hit;
    logic drain_miss;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic have_prev;
    logic empty;
    logic gen_last;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/rarb_if.sv @@
// Request and result channel interfaces of the resampling audio ring buffer.
`default_nettype none

interface rarb_in_if;
  import rarb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic signed [SAMPLE_W-1:0] sample_left;
  logic signed [SAMPLE_W-1:0] sample_right;
  logic                       first_of_batch;

  modport source (
    output valid, opcode, sample_left, sample_right, first_of_batch,
    input  ready
  );
  modport sink (
    input  valid, opcode, sample_left, sample_right, first_of_batch,
    output ready
  );
endinterface

interface rarb_out_if;
  import rarb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                       out_valid;
  logic [WCOUNT_W-1:0]        written_count;
  logic [BCOUNT_W-1:0]        buffered_count;

  modport source (
    output valid, out_left, out_right, out_valid, written_count, buffered_count,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_right, out_valid, written_count, buffered_count,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/rarb_ctrl.sv @@
// Controller state machine of the resampling audio ring buffer.
`default_nettype none

module rarb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire rarb_pkg::opcode_e opcode_i,
  input  wire logic              first_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire rarb_pkg::sts_t    sts_i,
  output rarb_pkg::cmd_t         cmd_o
);
  import rarb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_GEN   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   accept;
  logic   slot_free;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign slot_free  = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_DRAIN) begin
            cmd_o.drain_hit  = !sts_i.empty;
            cmd_o.drain_miss = sts_i.empty;
            state_d = ST_DONE;
          end else if (first_i || !sts_i.have_prev) begin
            cmd_o.store_first = 1'b1;
            state_d = ST_DONE;
          end else begin
            cmd_o.start_gen = 1'b1;
            state_d = ST_GEN;
          end
        end
      end
      ST_GEN: begin
        cmd_o.gen_step = 1'b1;
        if (sts_i.gen_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.finish_gen = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    if (cmd_o.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rarb_dpath.sv @@
// Datapath of the resampling audio ring buffer: interpolator, ring memory and result register.
`default_nettype none

module rarb_dpath #(
  parameter int unsigned BUFFER_DEPTH = 2048
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rarb_pkg::STEP_W-1:0]          cfg_data_i,
  input  wire logic signed [rarb_pkg::SAMPLE_W-1:0] sample_left_i,
  input  wire logic signed [rarb_pkg::SAMPLE_W-1:0] sample_right_i,
  input  wire rarb_pkg::cmd_t                       cmd_i,
  output rarb_pkg::sts_t                            sts_o,
  output logic signed [rarb_pkg::SAMPLE_W-1:0]      out_left_o,
  output logic signed [rarb_pkg::SAMPLE_W-1:0]      out_right_o,
  output logic                                      out_valid_o,
  output logic [rarb_pkg::WCOUNT_W-1:0]             written_count_o,
  output logic [rarb_pkg::BCOUNT_W-1:0]             buffered_count_o
);
  import rarb_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);

  // Ring memory, one stereo entry per address.
  logic [ENTRY_W-1:0] ring_mem [BUFFER_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  // Control state.
  logic [STEP_W-1:0]  step_q;
  logic [PHASE_W-1:0] phase_q;
  logic               have_prev_q;
  logic [AW-1:0]      wptr_q, rptr_q, count_q;
  logic               pipe_vld_q;
  logic [WCOUNT_W-1:0] wcount_q;
  logic               hit_q;

  // Payload state.
  logic signed [SAMPLE_W-1:0] prev_l_q, prev_r_q;
  logic signed [SAMPLE_W-1:0] cur_l_q, cur_r_q;
  logic signed [PROD_W-1:0]   prod_l_q, prod_r_q;

  logic [STEP_W-1:0]          step_c;
  logic [STEP_W-1:0]          phase_next;
  logic signed [DIFF_W-1:0]   diff_l, diff_r;
  logic signed [PROD_W-1:0]   prod_l_d, prod_r_d;
  logic signed [PHASE_W:0]    phase_s;
  logic [SAMPLE_W-1:0]        interp_l, interp_r;
  logic                       full;
  logic                       item_start;
  logic [AW-1:0]              wptr_inc, rptr_inc;

  // Step limited to the supported range.
  always_comb begin
    if (step_q < STEP_MIN) begin
      step_c = STEP_MIN;
    end else if (step_q > STEP_MAX) begin
      step_c = STEP_MAX;
    end else begin
      step_c = step_q;
    end
  end

  assign phase_next = {1'b0, phase_q} + step_c;

  // Multiply stage: difference times phase for both channels.
  assign phase_s  = $signed({1'b0, phase_q});
  assign diff_l   = DIFF_W'(cur_l_q) - DIFF_W'(prev_l_q);
  assign diff_r   = DIFF_W'(cur_r_q) - DIFF_W'(prev_r_q);
  assign prod_l_d = PROD_W'(diff_l) * PROD_W'(phase_s);
  assign prod_r_d = PROD_W'(diff_r) * PROD_W'(phase_s);

  // Write stage: floor of product over 4096 added to the previous sample, wrapped.
  assign interp_l = prev_l_q + prod_l_q[PHASE_W +: SAMPLE_W];
  assign interp_r = prev_r_q + prod_r_q[PHASE_W +: SAMPLE_W];

  assign full     = (count_q == LAST_IDX);
  assign wptr_inc = (wptr_q == LAST_IDX) ? '0 : wptr_q + 1'b1;
  assign rptr_inc = (rptr_q == LAST_IDX) ? '0 : rptr_q + 1'b1;
  assign item_start = cmd_i.store_first || cmd_i.start_gen || cmd_i.drain_hit ||
                      cmd_i.drain_miss;

  assign sts_o.have_prev = have_prev_q;
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.gen_last  = phase_next[PHASE_W];

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_RESET;
      phase_q     <= '0;
      have_prev_q <= 1'b0;
      wptr_q      <= '0;
      rptr_q      <= '0;
      count_q     <= '0;
      pipe_vld_q  <= 1'b0;
      wcount_q    <= '0;
      hit_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_data_i;
      end
      pipe_vld_q <= cmd_i.gen_step;
      if (cmd_i.store_first) begin
        phase_q     <= '0;
        have_prev_q <= 1'b1;
      end else if (cmd_i.gen_step) begin
        phase_q <= phase_next[PHASE_W-1:0];
      end
      if (item_start) begin
        wcount_q <= '0;
        hit_q    <= cmd_i.drain_hit;
      end else if (pipe_vld_q) begin
        wcount_q <= wcount_q + 1'b1;
      end
      // A write onto a full ring drops the oldest entry.
      if (pipe_vld_q) begin
        wptr_q <= wptr_inc;
        if (full) begin
          rptr_q <= rptr_inc;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end else if (cmd_i.drain_hit) begin
        rptr_q  <= rptr_inc;
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_first || cmd_i.finish_gen) begin
      prev_l_q <= cmd_i.store_first ? sample_left_i : cur_l_q;
      prev_r_q <= cmd_i.store_first ? sample_right_i : cur_r_q;
    end
    if (cmd_i.start_gen) begin
      cur_l_q <= sample_left_i;
      cur_r_q <= sample_right_i;
    end
    if (cmd_i.gen_step) begin
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
    end
  end

  // Ring memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (pipe_vld_q) begin
      ring_mem[wptr_q] <= {interp_l, interp_r};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.drain_hit) begin
      rdata_q <= ring_mem[rptr_q];
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_left_o       <= hit_q ? $signed(rdata_q[SAMPLE_W +: SAMPLE_W]) : '0;
      out_right_o      <= hit_q ? $signed(rdata_q[0 +: SAMPLE_W]) : '0;
      out_valid_o      <= hit_q;
      written_count_o  <= wcount_q;
      buffered_count_o <= BCOUNT_W'(count_q);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/resampling_audio_ring_buffer_top.sv @@
// Top level of the resampling audio ring buffer.
// A stereo linear-interpolation upsampler that fills a ring of BUFFER_DEPTH entries
// (at most BUFFER_DEPTH - 1 held; when full the oldest is overwritten). Each request
// returns one result through a result register, and a new request is taken while a
// finished result still waits there. A drain request and a push that only stores its
// sample go from acceptance to the DONE state, which loads their result and returns
// to idle. An interpolating push passes through the GEN, FLUSH and DONE states, where
// GEN writes the outputs of the push, 1 to 64 of them (about 4096 / phase_step), one
// ring entry per cycle through a single multiplier pair and the single memory write
// port. A result that is still waiting when the next one is done stalls the controller
// until it is taken. A request is taken only while the controller is idle. The ring
// needs no clearing after reset. The user must write phase_step through
// cfg_we_i/cfg_data_i only while the block is idle; the block does not enforce this.
`default_nettype none

`include "resampling_audio_ring_buffer_top_assert.svh"

module resampling_audio_ring_buffer_top #(
  parameter int unsigned BUFFER_DEPTH = 2048
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rarb_pkg::STEP_W-1:0] cfg_data_i,
  rarb_in_if.sink                          in_i,
  rarb_out_if.source                       out_o
);
  import rarb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller.
  rarb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .opcode_i    (opcode_e'(in_i.opcode)),
    .first_i     (in_i.first_of_batch),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  rarb_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .sample_left_i    (in_i.sample_left),
    .sample_right_i   (in_i.sample_right),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_left_o       (out_o.out_left),
    .out_right_o      (out_o.out_right),
    .out_valid_o      (out_o.out_valid),
    .written_count_o  (out_o.written_count),
    .buffered_count_o (out_o.buffered_count)
  );

  // A result without a drained sample carries zero samples.
  `RARB_ASSERT_IMP(a_zero_when_not_valid, out_o.valid && !out_o.out_valid,
    out_o.out_left == '0 && out_o.out_right == '0)
  // Only a push writes samples, so a drained sample comes with no written count.
  `RARB_ASSERT_IMP(a_drain_writes_none, out_o.valid && out_o.written_count != '0,
    !out_o.out_valid)
  // One push writes at most 64 samples.
  `RARB_ASSERT_IMP(a_written_bound, out_o.valid, out_o.written_count <= 7'd64)
  // The block is not ready in the cycle after it takes a request.
  `RARB_ASSERT_NXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)

endmodule

`default_nettype wire

@@ verif/rarb_result_monitor.sv @@
// Request/result monitor that predicts and checks every result of the resampling ring buffer.
module rarb_result_monitor
  import rarb_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [STEP_W-1:0] cfg_data_i,
  rarb_in_if                req_mon,
  rarb_out_if               rsp_mon,
  output int                mismatch_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ONE   = 1 << PHASE_W;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_l;
    logic signed [SAMPLE_W-1:0] sample_r;
    logic                       valid;
    logic [WCOUNT_W-1:0]        written;
    logic [BCOUNT_W-1:0]        held;
  } result_t;

  // Shadow copy of the block state.
  logic signed [SAMPLE_W-1:0] ring_left  [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] ring_right [RING_DEPTH];
  int unsigned                wr_ptr;
  int unsigned                rd_ptr;
  int                         phase_acc;
  logic signed [SAMPLE_W-1:0] prev_l;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic                       have_prev;
  logic [STEP_W-1:0]          step_reg;

  result_t expected_results [$];
  result_t got;
  result_t want;

  // Linear interpolation between two samples, with the product floored by the shift.
  function automatic logic signed [SAMPLE_W-1:0] lerp(
    input logic signed [SAMPLE_W-1:0] x0,
    input logic signed [SAMPLE_W-1:0] x1,
    input int                         ph
  );
    int prod;
    prod = (int'(x1) - int'(x0)) * ph;
    return SAMPLE_W'(int'(x0) + (prod >>> PHASE_W));
  endfunction

  // Applies one request to the shadow state and returns the result it should produce.
  function automatic result_t predict_request(
    input opcode_e                    op,
    input logic signed [SAMPLE_W-1:0] in_l,
    input logic signed [SAMPLE_W-1:0] in_r,
    input logic                       fob
  );
    result_t     res;
    int          step;
    int unsigned written;
    res     = '0;
    written = 0;
    if (op == OP_PUSH) begin
      if (fob || !have_prev) begin
        phase_acc = 0;
      end else begin
        step = int'(step_reg);
        if (step < int'(STEP_MIN)) step = int'(STEP_MIN);
        if (step > int'(STEP_MAX)) step = int'(STEP_MAX);
        // One ring entry per phase point until the phase passes the new sample.
        while (phase_acc < PHASE_ONE) begin
          ring_left[wr_ptr]  = lerp(prev_l, in_l, phase_acc);
          ring_right[wr_ptr] = lerp(prev_r, in_r, phase_acc);
          wr_ptr = (wr_ptr + 1) % RING_DEPTH;
          // A full ring drops its oldest entry.
          if (wr_ptr == rd_ptr) rd_ptr = (rd_ptr + 1) % RING_DEPTH;
          written++;
          phase_acc += step;
        end
        phase_acc = phase_acc % PHASE_ONE;
      end
      prev_l    = in_l;
      prev_r    = in_r;
      have_prev = 1'b1;
    end else if (rd_ptr != wr_ptr) begin
      res.sample_l = ring_left[rd_ptr];
      res.sample_r = ring_right[rd_ptr];
      res.valid    = 1'b1;
      rd_ptr       = (rd_ptr + 1) % RING_DEPTH;
    end
    res.written = WCOUNT_W'(written);
    res.held    = BCOUNT_W'((wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH);
    return res;
  endfunction

  // Track configuration, predict accepted requests and check accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_reg   = STEP_RESET;
      wr_ptr     = 0;
      rd_ptr     = 0;
      phase_acc  = 0;
      prev_l     = '0;
      prev_r     = '0;
      have_prev  = 1'b0;
      mismatch_o = 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) step_reg = cfg_data_i;

      // Results are checked first: one arriving now always belongs to an older request.
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{rsp_mon.out_left, rsp_mon.out_right, rsp_mon.out_valid,
                rsp_mon.written_count, rsp_mon.buffered_count};
        if (expected_results.size() == 0) begin
          if (mismatch_o < MAX_REPORTS)
            $display("[%0t] result without a pending request: l=%0d r=%0d v=%0b wc=%0d bc=%0d",
                     $realtime, got.sample_l, got.sample_r, got.valid, got.written, got.held);
          mismatch_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.sample_l !== want.sample_l || got.sample_r !== want.sample_r ||
              got.valid !== want.valid || got.written !== want.written ||
              got.held !== want.held) begin
            if (mismatch_o < MAX_REPORTS) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected l=%0d r=%0d v=%0b wc=%0d bc=%0d",
                       want.sample_l, want.sample_r, want.valid, want.written, want.held);
              $display("  actual   l=%0d r=%0d v=%0b wc=%0d bc=%0d",
                       got.sample_l, got.sample_r, got.valid, got.written, got.held);
            end
            mismatch_o++;
          end
        end
      end

      if (req_mon.valid && req_mon.ready)
        expected_results.push_back(predict_request(opcode_e'(req_mon.opcode),
                                                   req_mon.sample_left, req_mon.sample_right,
                                                   req_mon.first_of_batch));
    end
    pending_o = expected_results.size();
  end

endmodule

@@ verif/tb_resampling_audio_ring_buffer_top.sv @@
// Testbench top: clock, reset, request and result traffic, and the final verdict.
module tb_resampling_audio_ring_buffer_top
  import rarb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH  = 2048;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_WAIT  = 70;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [STEP_W-1:0] cfg_data;
  int                mismatches;
  int                pending;
  int unsigned       cycle_count = 0;
  int unsigned       tx_idle_pct;
  int unsigned       rx_idle_pct;

  rarb_in_if  req_if ();
  rarb_out_if rsp_if ();

  resampling_audio_ring_buffer_top #(
    .BUFFER_DEPTH (RING_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  rarb_result_monitor #(
    .RING_DEPTH (RING_DEPTH)
  ) i_monitor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .req_mon    (req_if),
    .rsp_mon    (rsp_if),
    .mismatch_o (mismatches),
    .pending_o  (pending)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The result side stalls at random.
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Sample values with the extremes and zero well represented.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Step values, mostly in range, sometimes at or beyond either end.
  function automatic logic [STEP_W-1:0] rand_step();
    case ($urandom_range(9))
      0:       return STEP_MIN;
      1:       return STEP_MAX;
      2:       return STEP_W'($urandom_range(0, 63));
      3:       return STEP_W'($urandom_range(4097, 8191));
      default: return STEP_W'($urandom_range(64, 4096));
    endcase
  endfunction

  // Offers one request after a random number of idle cycles and waits until it is taken.
  task automatic send_request(input opcode_e op, input logic signed [SAMPLE_W-1:0] in_l,
                              input logic signed [SAMPLE_W-1:0] in_r, input logic fob);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.opcode         <= op;
    req_if.sample_left    <= in_l;
    req_if.sample_right   <= in_r;
    req_if.first_of_batch <= fob;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Waits for every outstanding result, then writes the step register.
  task automatic write_phase_step(input logic [STEP_W-1:0] value);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Random traffic: batches that open with a first-of-batch push, drains mixed in,
  // and the odd stray batch restart.
  task automatic run_segment(input int unsigned n_items, input int unsigned push_pct);
    int unsigned batch_left;
    logic        fob;
    batch_left = 0;
    repeat (n_items) begin
      if ($urandom_range(99) < push_pct) begin
        if (batch_left == 0) begin
          fob        = 1'b1;
          batch_left = $urandom_range(2, 12);
        end else begin
          fob = ($urandom_range(19) == 0);
          batch_left--;
        end
        send_request(OP_PUSH, rand_sample(), rand_sample(), fob);
      end else begin
        send_request(OP_DRAIN, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                     1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int unsigned mode;
    int unsigned seg;
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_data              = '0;
    req_if.valid          = 1'b0;
    req_if.opcode         = OP_PUSH;
    req_if.sample_left    = '0;
    req_if.sample_right   = '0;
    req_if.first_of_batch = 1'b0;
    rsp_if.ready          = 1'b0;
    tx_idle_pct           = 33;
    rx_idle_pct           = 50;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty ring, push with no previous sample, reset step of one output per push.
    send_request(OP_DRAIN, '0, '0, 1'b0);
    send_request(OP_PUSH, 16'sh7FFF, 16'sh8000, 1'b0);
    send_request(OP_PUSH, 16'sh8000, 16'sh7FFF, 1'b0);
    send_request(OP_PUSH, '0, '0, 1'b1);
    send_request(OP_DRAIN, 16'shFFFF, 16'shFFFF, 1'b1);
    send_request(OP_DRAIN, '0, '0, 1'b0);

    // Smallest step: after a first-of-batch store, full-scale swings in both directions give 64 outputs per push.
    write_phase_step(STEP_MIN);
    send_request(OP_PUSH, 16'sh8000, 16'sh7FFF, 1'b1);
    send_request(OP_PUSH, 16'sh7FFF, 16'sh8000, 1'b0);
    send_request(OP_PUSH, 16'shFFFF, 16'sh0001, 1'b0);
    repeat (3) send_request(OP_DRAIN, '0, '0, 1'b0);

    // Steps below and above the legal range are clamped.
    write_phase_step('0);
    send_request(OP_PUSH, 16'sh5555, 16'shAAAA, 1'b0);
    send_request(OP_DRAIN, '0, '0, 1'b0);
    write_phase_step('1);
    send_request(OP_PUSH, 16'shAAAA, 16'sh5555, 1'b0);
    send_request(OP_DRAIN, '0, '0, 1'b0);

    // A step just short of one source period leaves a phase remainder that accumulates.
    write_phase_step(13'd4095);
    repeat (3) send_request(OP_PUSH, rand_sample(), rand_sample(), 1'b0);
    write_phase_step(13'd1);
    send_request(OP_PUSH, rand_sample(), rand_sample(), 1'b0);
    send_request(OP_DRAIN, '0, '0, 1'b0);

    // Random traffic under three idling patterns.
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 50;
        end
        1: begin
          tx_idle_pct = 50;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < 6; seg++) begin
        write_phase_step(rand_step());
        run_segment(72, $urandom_range(10, 70));
      end
    end

    // Overfill the ring so the oldest entries get overwritten and both pointers wrap.
    write_phase_step(STEP_MIN);
    send_request(OP_PUSH, rand_sample(), rand_sample(), 1'b1);
    repeat (33) send_request(OP_PUSH, rand_sample(), rand_sample(), 1'b0);
    repeat (40) send_request(OP_DRAIN, '0, '0, 1'b0);
    req_if.valid <= 1'b0;

    // Let every outstanding result come back, then allow for stragglers.
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/rarb_pkg.sv
hw/rtl/rarb_if.sv
hw/rtl/rarb_ctrl.sv
hw/rtl/rarb_dpath.sv
hw/rtl/resampling_audio_ring_buffer_top.sv
verif/rarb_result_monitor.sv
verif/tb_resampling_audio_ring_buffer_top.sv
